// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising clk edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/tuc_pkg.sv
// ----------------------------------------------------------------------------
// tuc_pkg
// Types, codes and character helpers for the text to unsigned converter
// ----------------------------------------------------------------------------
package tuc_pkg;

  localparam int BASE_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int STAT_W  = 2;
  localparam int BIT_W   = 3;

  // radix limits
  localparam logic [BASE_W-1:0] BASE_DEFAULT = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] DIGIT_NONE   = 6'd63;
  localparam logic [BIT_W-1:0]  BIT_LAST     = 3'(BASE_W - 1);

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_BASE = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z    = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LO_A    = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LO_Z    = 8'd122;
  localparam logic [CHAR_W-1:0] CH_CASE    = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT      = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF      = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd55;

  // parse phase of the current string
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LEAD   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } seq_t;

  // digit value of a character in any case, DIGIT_NONE if not alphanumeric
  function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [BASE_W-1:0] v;
    u = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CH_CASE : c;
    if (u >= CH_ZERO && u <= CH_NINE) begin
      v = BASE_W'(u - CH_ZERO);
    end else if (u >= CH_UP_A && u <= CH_UP_Z) begin
      v = BASE_W'(u - LETTER_OFS);
    end else begin
      v = DIGIT_NONE;
    end
    return v;
  endfunction

  // leading whitespace that is skipped (space is not)
  function automatic logic is_skip_space(input logic [CHAR_W-1:0] c);
    return c == CH_FF || c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_VT;
  endfunction

endpackage

// File: hw/rtl/text_to_unsigned_converter_top.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_converter_top
// Character-serial text to unsigned integer converter, radix 2 to 36
// ----------------------------------------------------------------------------
// A string enters one character per input beat, and a digit character passes
// from accept to the next ready through accept, decode, the shared shift-add
// unit that multiplies the running value by the base one base bit per cycle,
// and the digit add and range check. Whitespace, plus and characters that
// are ignored pass through accept and decode only. A result sits in the
// output register while the next characters are taken; only a character
// that must itself report waits in decode or range check until the output
// register is free.
`include "assert_macros.svh"

module text_to_unsigned_converter_top #(
  parameter int WORD_BITS  = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [tuc_pkg::BASE_W-1:0]          cfg_wdata,
  // character input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_first_char,
  input  logic [tuc_pkg::CHAR_W-1:0]          in_char_code,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [WORD_BITS-1:0]                out_value,
  output logic [tuc_pkg::STAT_W-1:0]          out_status,
  output logic [COUNT_BITS-1:0]               out_consumed
);

  localparam int PROD_W = WORD_BITS + tuc_pkg::BASE_W + 1;

  tuc_pkg::seq_t                  state_r, state_nxt;
  tuc_pkg::phase_t                phase_r, phase_nxt;
  logic [tuc_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [WORD_BITS-1:0]           acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic [tuc_pkg::CHAR_W-1:0]     char_r, char_nxt;
  logic [PROD_W-1:0]              prod_r, prod_nxt;
  logic [tuc_pkg::BASE_W-1:0]     digit_r, digit_nxt;
  logic [tuc_pkg::BIT_W-1:0]      bit_r, bit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0]           out_value_r, out_value_nxt;
  logic [tuc_pkg::STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [COUNT_BITS-1:0]          out_cnt_r, out_cnt_nxt;

  logic [tuc_pkg::BASE_W-1:0]     base_eff;
  logic                           base_ok;
  logic [tuc_pkg::BASE_W-1:0]     dval;
  logic [COUNT_BITS-1:0]          cnt_bump;
  logic [PROD_W-1:0]              sum;
  logic                           ovf;
  logic                           slot_free;

  // effective radix and decode of the held character
  assign base_eff  = (base_r == '0) ? tuc_pkg::BASE_DEFAULT : base_r;
  assign base_ok   = (base_eff >= tuc_pkg::BASE_MIN) && (base_eff <= tuc_pkg::BASE_MAX);
  assign dval      = tuc_pkg::digit_value(char_r);
  assign cnt_bump  = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_BITS'(1);
  assign sum       = prod_r + PROD_W'(digit_r);
  assign ovf       = |sum[PROD_W-1:WORD_BITS];
  assign slot_free = !out_valid_r || out_ready;

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    base_nxt       = cfg_we ? cfg_wdata : base_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    char_nxt       = char_r;
    prod_nxt       = prod_r;
    digit_nxt      = digit_r;
    bit_nxt        = bit_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;

    case (state_r)
      tuc_pkg::S_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_char_code;
          state_nxt = tuc_pkg::S_EVAL;
          if (in_first_char) begin
            phase_nxt = tuc_pkg::PH_LEAD;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
      end
      tuc_pkg::S_EVAL: begin
        if (phase_r == tuc_pkg::PH_IDLE) begin
          state_nxt = tuc_pkg::S_IDLE;
        end else if (!base_ok) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = tuc_pkg::STAT_BAD_BASE;
            out_cnt_nxt    = '0;
            phase_nxt      = tuc_pkg::PH_IDLE;
            state_nxt      = tuc_pkg::S_IDLE;
          end
        end else if (phase_r == tuc_pkg::PH_LEAD && tuc_pkg::is_skip_space(char_r)) begin
          cnt_nxt   = cnt_bump;
          state_nxt = tuc_pkg::S_IDLE;
        end else if (phase_r == tuc_pkg::PH_LEAD && char_r == tuc_pkg::CH_PLUS) begin
          cnt_nxt   = cnt_bump;
          phase_nxt = tuc_pkg::PH_DIGITS;
          state_nxt = tuc_pkg::S_IDLE;
        end else if (dval >= base_eff) begin
          // first non-digit ends the string
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = acc_r;
            out_status_nxt = tuc_pkg::STAT_OK;
            out_cnt_nxt    = cnt_r;
            phase_nxt      = tuc_pkg::PH_IDLE;
            state_nxt      = tuc_pkg::S_IDLE;
          end
        end else begin
          digit_nxt = dval;
          prod_nxt  = '0;
          bit_nxt   = tuc_pkg::BIT_LAST;
          state_nxt = tuc_pkg::S_MUL;
        end
      end
      tuc_pkg::S_MUL: begin
        // msb-first shift-add over the base bits
        prod_nxt = {prod_r[PROD_W-2:0], 1'b0} +
                   (base_eff[bit_r] ? PROD_W'(acc_r) : '0);
        if (bit_r == '0) begin
          state_nxt = tuc_pkg::S_FIN;
        end else begin
          bit_nxt = bit_r - tuc_pkg::BIT_W'(1);
        end
      end
      tuc_pkg::S_FIN: begin
        if (ovf) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '1;
            out_status_nxt = tuc_pkg::STAT_RANGE;
            out_cnt_nxt    = cnt_r;
            phase_nxt      = tuc_pkg::PH_IDLE;
            state_nxt      = tuc_pkg::S_IDLE;
          end
        end else begin
          acc_nxt   = sum[WORD_BITS-1:0];
          cnt_nxt   = cnt_bump;
          phase_nxt = tuc_pkg::PH_DIGITS;
          state_nxt = tuc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tuc_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tuc_pkg::S_IDLE;
      phase_r     <= tuc_pkg::PH_IDLE;
      base_r      <= tuc_pkg::BASE_DEFAULT;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      base_r      <= base_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r       <= char_nxt;
    prod_r       <= prod_nxt;
    digit_r      <= digit_nxt;
    bit_r        <= bit_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // no beat is taken while reset is held
  assign in_ready     = rst_n && (state_r == tuc_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;
  assign out_consumed = out_cnt_r;

  // checks
  `ASSERT_PROP(a_accept_to_eval, (in_valid && in_ready) |=> (state_r == tuc_pkg::S_EVAL),
               "accepted beat did not move to decode")
  `ASSERT_PROP(a_mul_steps, (state_r == tuc_pkg::S_MUL && bit_r != '0) |=>
               (state_r == tuc_pkg::S_MUL), "multiply left before last base bit")
  `ASSERT_PROP(a_bad_base_zero, (out_valid && out_status == tuc_pkg::STAT_BAD_BASE) |->
               (out_value == '0 && out_consumed == '0), "bad base result not zero")
  `ASSERT_NEVER(a_status_code, out_valid && out_status != tuc_pkg::STAT_OK &&
                out_status != tuc_pkg::STAT_RANGE && out_status != tuc_pkg::STAT_BAD_BASE,
                "undefined status on output")

endmodule

// File: tb/text_to_unsigned_converter_top_test.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_converter_top_test
// Checks the character-serial text to unsigned converter against a
// behavioral model kept in a scoreboard, over directed strings and random
// strings in a range of radix settings, with random gaps on both channels
// and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_to_unsigned_converter_top_test;

  localparam int WORD_BITS  = 64;
  localparam int COUNT_BITS = 32;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam logic [tuc_pkg::CHAR_W-1:0] CH_NUL   = 8'd0;
  localparam logic [tuc_pkg::CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [WORD_BITS-1:0] WORD_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct {
    logic [WORD_BITS-1:0]       value;
    logic [tuc_pkg::STAT_W-1:0] status;
    logic [COUNT_BITS-1:0]      consumed;
  } conv_result_t;

  // model of the converter plus the queue of results it still owes
  class conversion_tracker;
    tuc_pkg::phase_t            ph;
    logic [WORD_BITS-1:0]       acc;
    logic [COUNT_BITS-1:0]      cnt;
    logic [tuc_pkg::BASE_W-1:0] base_reg;
    conv_result_t               owed_results[$];
    int                         errors;

    function new();
      ph = tuc_pkg::PH_IDLE;
      acc = '0;
      cnt = '0;
      base_reg = tuc_pkg::BASE_DEFAULT;
      errors = 0;
    endfunction

    function void set_base(logic [tuc_pkg::BASE_W-1:0] b);
      base_reg = b;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // digit value of a character ignoring case, -1 when not alphanumeric
    function int char_value(logic [tuc_pkg::CHAR_W-1:0] c);
      logic [tuc_pkg::CHAR_W-1:0] u;
      u = c;
      if (c >= tuc_pkg::CH_LO_A && c <= tuc_pkg::CH_LO_Z) begin
        u = c - tuc_pkg::CH_CASE;
      end
      if (u >= tuc_pkg::CH_ZERO && u <= tuc_pkg::CH_NINE) begin
        return int'(u - tuc_pkg::CH_ZERO);
      end
      if (u >= tuc_pkg::CH_UP_A && u <= tuc_pkg::CH_UP_Z) begin
        return int'(u - tuc_pkg::CH_UP_A) + 10;
      end
      return -1;
    endfunction

    function void report(logic [WORD_BITS-1:0] v, logic [tuc_pkg::STAT_W-1:0] s,
                         logic [COUNT_BITS-1:0] n);
      conv_result_t r;
      r.value = v;
      r.status = s;
      r.consumed = n;
      owed_results.push_back(r);
      ph = tuc_pkg::PH_IDLE;
    endfunction

    function void bump();
      if (cnt != COUNT_MAX) begin
        cnt = cnt + 1'b1;
      end
    endfunction

    // advance the model by one accepted character
    function void take_char(bit first, logic [tuc_pkg::CHAR_W-1:0] c);
      int radix;
      int dv;
      logic [WORD_BITS-1:0] quo;
      logic [WORD_BITS-1:0] rem;
      if (first) begin
        ph = tuc_pkg::PH_LEAD;
        acc = '0;
        cnt = '0;
      end
      if (ph == tuc_pkg::PH_IDLE) begin
        return;
      end
      radix = (base_reg == '0) ? int'(tuc_pkg::BASE_DEFAULT) : int'(base_reg);
      if (radix < int'(tuc_pkg::BASE_MIN) || radix > int'(tuc_pkg::BASE_MAX)) begin
        report('0, tuc_pkg::STAT_BAD_BASE, '0);
        return;
      end
      // leading part: skipped whitespace and one plus
      if (ph == tuc_pkg::PH_LEAD) begin
        if (c == tuc_pkg::CH_TAB || c == tuc_pkg::CH_LF || c == tuc_pkg::CH_VT ||
            c == tuc_pkg::CH_FF || c == tuc_pkg::CH_CR) begin
          bump();
          return;
        end
        if (c == tuc_pkg::CH_PLUS) begin
          bump();
          ph = tuc_pkg::PH_DIGITS;
          return;
        end
      end
      dv = char_value(c);
      if (dv < 0 || dv >= radix) begin
        report(acc, tuc_pkg::STAT_OK, cnt);
        return;
      end
      // range check before the multiply-add
      quo = WORD_MAX / WORD_BITS'(radix);
      rem = WORD_MAX % WORD_BITS'(radix);
      if (acc > quo || (acc == quo && WORD_BITS'(dv) > rem)) begin
        report(WORD_MAX, tuc_pkg::STAT_RANGE, cnt);
        return;
      end
      acc = acc * WORD_BITS'(radix) + WORD_BITS'(dv);
      bump();
      ph = tuc_pkg::PH_DIGITS;
    endfunction

    function void check_result(logic [WORD_BITS-1:0] v, logic [tuc_pkg::STAT_W-1:0] s,
                               logic [COUNT_BITS-1:0] n);
      conv_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d consumed %0d",
                 $time, v, s, n);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (v !== want.value) begin
        $display("%0t: value mismatch, expected %h actual %h", $time, want.value, v);
        errors++;
      end
      if (s !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, s);
        errors++;
      end
      if (n !== want.consumed) begin
        $display("%0t: consumed mismatch, expected %0d actual %0d",
                 $time, want.consumed, n);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [tuc_pkg::BASE_W-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_first_char = 1'b0;
  logic [tuc_pkg::CHAR_W-1:0] in_char_code = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [WORD_BITS-1:0]       out_value;
  logic [tuc_pkg::STAT_W-1:0] out_status;
  logic [COUNT_BITS-1:0]      out_consumed;

  conversion_tracker tracker = new();
  logic [tuc_pkg::BASE_W-1:0] cur_base = tuc_pkg::BASE_DEFAULT;
  int  in_burst = 0;
  int  out_burst = 0;
  bit  hold_req = 1'b0;
  int  cycles = 0;

  text_to_unsigned_converter_top #(
    .WORD_BITS  (WORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_first_char (in_first_char),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_status    (out_status),
    .out_consumed  (out_consumed)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("text_to_unsigned_converter_top_test: errors");
      $finish;
    end
  end

  // input and output beat monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tracker.take_char(in_first_char, in_char_code);
    end
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(out_value, out_status, out_consumed);
    end
  end

  // wait before a beat: random, with runs of back-to-back beats
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // result receiver with random stalls and one long hold-off
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap(out_burst);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_char(input bit first, input logic [tuc_pkg::CHAR_W-1:0] code);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_char <= first;
    in_char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until all owed results are out and the block settles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [tuc_pkg::BASE_W-1:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_base(b);
    cur_base = b;
  endtask

  function automatic logic [tuc_pkg::CHAR_W-1:0] digit_char(int v);
    if (v < 10) begin
      return tuc_pkg::CH_ZERO + tuc_pkg::CHAR_W'(v);
    end
    return ($urandom_range(0, 1) ? tuc_pkg::CH_UP_A : tuc_pkg::CH_LO_A) +
           tuc_pkg::CHAR_W'(v - 10);
  endfunction

  // fewest max digits that reach or pass the word maximum
  function automatic int overflow_len(int radix);
    logic [127:0] p;
    int n;
    p = 128'd1;
    n = 0;
    while (p < (128'd1 << WORD_BITS)) begin
      p = p * radix;
      n++;
    end
    return n;
  endfunction

  // one random string; returns how many characters counted toward the budget
  task automatic send_string(output int sent);
    logic [tuc_pkg::CHAR_W-1:0] ws_codes[5];
    logic [tuc_pkg::CHAR_W-1:0] chars[$];
    logic [tuc_pkg::CHAR_W-1:0] term;
    int radix;
    int kind;
    int len;
    ws_codes = '{tuc_pkg::CH_TAB, tuc_pkg::CH_LF, tuc_pkg::CH_VT,
                 tuc_pkg::CH_FF, tuc_pkg::CH_CR};
    radix = (cur_base == '0) ? 10 : int'(cur_base);
    if (radix < 2 || radix > 36) begin
      radix = 10;
    end
    kind = $urandom_range(0, 99);
    sent = 0;
    if (kind >= 72 && kind < 87) begin
      // noise: random bytes with random string starts
      len = $urandom_range(1, 4);
      repeat (len) send_char($urandom_range(0, 1),
                             tuc_pkg::CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if (kind >= 62 && kind < 72) begin
      // long run near the word maximum
      if ($urandom_range(0, 1)) begin
        chars.push_back(tuc_pkg::CH_PLUS);
      end
      len = overflow_len(radix) + $urandom_range(0, 2) - 1;
      chars.push_back(digit_char(radix - 1));
      for (int i = 1; i < len; i++) begin
        chars.push_back(digit_char($urandom_range(0, 3) != 0 ? radix - 1
                                                          : $urandom_range(0, radix - 1)));
      end
    end else begin
      // short string: optional whitespace, optional plus, a few digits
      len = $urandom_range(0, 2);
      repeat (len) chars.push_back(ws_codes[$urandom_range(0, 4)]);
      if ($urandom_range(0, 1)) begin
        chars.push_back(tuc_pkg::CH_PLUS);
      end
      len = $urandom_range(0, 6);
      repeat (len) chars.push_back(digit_char($urandom_range(0, radix - 1)));
    end
    // broken strings end without a terminator and are cut by the next start
    if (kind < 87) begin
      term = ($urandom_range(0, 2) == 0) ? tuc_pkg::CHAR_W'($urandom_range(0, 255))
                                         : CH_NUL;
      chars.push_back(term);
    end else if (chars.size() == 0) begin
      chars.push_back(tuc_pkg::CH_ZERO);
    end
    foreach (chars[i]) send_char(i == 0, chars[i]);
    sent = chars.size();
  endtask

  task automatic run_phase(input logic [tuc_pkg::BASE_W-1:0] b, input int budget);
    int done;
    int sent;
    write_base(b);
    done = 0;
    while (done < budget) begin
      send_string(sent);
      done += sent;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every skipped whitespace, plus, digit, then a letter that ends base ten
    send_char(1'b1, tuc_pkg::CH_TAB);
    send_char(1'b0, tuc_pkg::CH_LF);
    send_char(1'b0, tuc_pkg::CH_VT);
    send_char(1'b0, tuc_pkg::CH_FF);
    send_char(1'b0, tuc_pkg::CH_CR);
    send_char(1'b0, tuc_pkg::CH_PLUS);
    send_char(1'b0, tuc_pkg::CH_NINE);
    send_char(1'b0, tuc_pkg::CH_LO_Z);
    // zero then terminator
    send_char(1'b1, tuc_pkg::CH_ZERO);
    send_char(1'b0, CH_NUL);
    // character while idle
    send_char(1'b0, 8'hFF);
    // new string before the old one ends
    send_char(1'b1, tuc_pkg::CH_ZERO + 8'd5);
    send_char(1'b1, tuc_pkg::CH_ZERO + 8'd7);
    send_char(1'b0, CH_NUL);
    // space is not whitespace
    send_char(1'b1, CH_SPACE);
    // second plus ends the string
    send_char(1'b1, tuc_pkg::CH_PLUS);
    send_char(1'b1, tuc_pkg::CH_PLUS);
    send_char(1'b0, tuc_pkg::CH_PLUS);
    // letters in both cases at the top radix
    write_base(tuc_pkg::BASE_MAX);
    send_char(1'b1, tuc_pkg::CH_LO_Z);
    send_char(1'b0, tuc_pkg::CH_UP_Z);
    send_char(1'b0, tuc_pkg::CH_UP_A);
    send_char(1'b0, CH_NUL);

    // random phases over several radix settings
    hold_req = 1'b1;
    run_phase(6'd0, 45);
    run_phase(tuc_pkg::BASE_MIN, 45);
    run_phase(tuc_pkg::BASE_MAX, 45);
    run_phase(6'd1, 12);
    run_phase(6'd16, 45);
    run_phase(6'd63, 12);
    run_phase(tuc_pkg::BASE_DEFAULT, 45);
    run_phase(6'd37, 12);
    run_phase(6'd7, 45);
    run_phase(tuc_pkg::BASE_DEFAULT, 30);

    drain();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("text_to_unsigned_converter_top_test: clean");
    end else begin
      $display("text_to_unsigned_converter_top_test: errors");
    end
    $finish;
  end

endmodule
